@@ hdl/average_range_band_levels_macros.svh @@
// assertion macros for the range band levels block and its checker
// no dependencies; included by files that hold concurrent assertions
`ifndef AVERAGE_RANGE_BAND_LEVELS_MACROS_SVH
`define AVERAGE_RANGE_BAND_LEVELS_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ARBL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arbl check failed");

// next-cycle implication, disabled while reset is low
`define ARBL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arbl check failed");

`endif

@@ hdl/arbl_pkg.sv @@
// shared types, codes and default sizes of the range band levels block
// no dependencies; imported by the top level, its checker and the testbench
package arbl_pkg;

    // default sizes handed to the top level parameters
    localparam int TABLE_DEPTH_DEF   = 4096;
    localparam int PRICE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 8;

    // fixed field widths
    localparam int STAMP_W    = 40;
    localparam int PERIOD_W   = 8;
    localparam int LEVEL_W    = 43;
    localparam int NUM_LEVELS = 5;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int OUT_DW     = ((NUM_LEVELS * LEVEL_W + 7) / 8) * 8;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(14);

    // input word kind
    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2
    } t_mode;

    // result word status
    typedef enum logic [STATUS_W-1:0] {
        STS_LEVELS    = 3'd0,
        STS_NO_LEVELS = 3'd1,
        STS_STORED    = 3'd2,
        STS_FULL      = 3'd3,
        STS_CLEARED   = 3'd4
    } t_status;

    // order in which the shared adder forms the outer and half levels
    typedef enum logic [1:0] {
        LS_TOP    = 2'd0,
        LS_UPPER  = 2'd1,
        LS_LOWER  = 2'd2,
        LS_BOTTOM = 2'd3
    } t_lstep;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_FIRST_RD,
        S_FIRST_CHK,
        S_LAST_RD,
        S_LAST_CHK,
        S_BIS_SEL,
        S_BIS_RD,
        S_BIS_CHK,
        S_SUM_INIT,
        S_OPEN_RD,
        S_OPEN_GET,
        S_SUM_SEL,
        S_SUM_ACC,
        S_DIV,
        S_ZERO_CHK,
        S_LEVEL,
        S_DONE
    } t_state;

endpackage

@@ hdl/average_range_band_levels.sv @@
// top level of the range band levels block: bar table, bisection, range sum,
// serial divider and level adder under one sequencer; depends on arbl_pkg
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  mode, bar high/low/open, stamp
// m_axis    out  m_axis_tvalid / m_axis_tready  status, five levels
// cfg       in   i_cfg_valid / o_cfg_ready      range_period
//
// clear, append, unused-mode, empty-table and zero-period query words go from accept straight to the done state
// a query reads the first and the last bar, bisects between them, reads the open of the found bar,
//   sums the earlier ranges, divides serially and forms the levels; a target that clamps to either end
//   skips the bisection, a zero range skips the levels; one table read per bisection or sum step
// the next word can be taken from the first cycle in which the previous result is in the output register
// reset clears the bar count and sets the period to 14; table contents are kept
module average_range_band_levels
    import arbl_pkg::*;
#(
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
    parameter int PRICE_WIDTH   = PRICE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // bar_high, bar_low, bar_open, stamp, zero pad
    input  logic [((3*PRICE_WIDTH+STAMP_W+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic [MODE_W-1:0]     s_axis_tuser,
    // result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // level_top, level_upper_half, level_mid, level_lower_half, level_bottom, zero pad
    output logic [OUT_DW-1:0]     m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]   m_axis_tuser,
    // range period register
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [PERIOD_W-1:0]   i_cfg_data
);

    localparam int ROW_W  = 3 * PRICE_WIDTH + STAMP_W;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int MAG_W  = PRICE_WIDTH + PERIOD_W;
    localparam int SUM_W  = MAG_W + 1;
    localparam int DIV_W  = MAG_W + FRACTION_BITS;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int CMP_W  = IDX_W + PERIOD_W;
    localparam int PAD_W  = OUT_DW - NUM_LEVELS * LEVEL_W;

    // sequencer and control registers
    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_count;
    logic [PERIOD_W-1:0]        r_period;
    logic                       r_out_valid;

    // bar table, one row per bar: time, open, low, high from the top down
    logic [ROW_W-1:0]           r_mem [TABLE_DEPTH];
    logic [ROW_W-1:0]           r_rdata;
    logic [IDX_W-1:0]           r_addr;

    // query working registers
    logic [STAMP_W-1:0]         r_tgt;
    logic [IDX_W-1:0]           r_lo;
    logic [IDX_W-1:0]           r_hi;
    logic [IDX_W-1:0]           r_base;
    logic [PERIOD_W-1:0]        r_left;
    logic signed [SUM_W-1:0]    r_sum;
    logic                       r_neg;
    logic [PRICE_WIDTH-1:0]     r_open;
    logic [DIV_W-1:0]           r_quo;
    logic [PERIOD_W-1:0]        r_rem;
    logic [DCNT_W-1:0]          r_dcnt;
    t_lstep                     r_lstep;
    t_status                    r_status;
    logic [LEVEL_W-1:0]         r_lv_top;
    logic [LEVEL_W-1:0]         r_lv_upper;
    logic [LEVEL_W-1:0]         r_lv_mid;
    logic [LEVEL_W-1:0]         r_lv_lower;
    logic [LEVEL_W-1:0]         r_lv_bottom;

    // result register
    t_status                    r_out_status;
    logic [NUM_LEVELS*LEVEL_W-1:0] r_out_levels;

    // combinational helpers
    logic                       w_in_take;
    logic                       w_cfg_take;
    logic                       w_out_load;
    logic                       w_mem_wr;
    t_mode                      w_mode;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_query_go;
    logic [CNT_W-1:0]           w_last_full;
    logic [IDX_W-1:0]           w_last;
    logic [PRICE_WIDTH-1:0]     w_rd_high;
    logic [PRICE_WIDTH-1:0]     w_rd_low;
    logic [PRICE_WIDTH-1:0]     w_rd_open;
    logic [STAMP_W-1:0]         w_rd_time;
    logic [IDX_W:0]             w_mid_sum;
    logic [IDX_W-1:0]           w_bis_mid;
    logic [IDX_W-1:0]           w_gap;
    logic                       w_more;
    logic                       w_base_big;
    logic [PERIOD_W-1:0]        w_terms;
    logic signed [SUM_W-1:0]    w_diff;
    logic [SUM_W-1:0]           w_sum_abs;
    logic [MAG_W-1:0]           w_mag;
    logic [PERIOD_W:0]          w_trial;
    logic                       w_trial_ge;
    logic [PERIOD_W:0]          w_trial_sub;
    logic [LEVEL_W-1:0]         w_lv_base;
    logic [LEVEL_W-1:0]         w_amag;
    logic [LEVEL_W-1:0]         w_hmag;
    logic [LEVEL_W-1:0]         w_lv_b;
    logic                       w_lv_sub;
    logic [LEVEL_W-1:0]         w_lv_res;

    // handshake and table status
    assign w_in_take   = s_axis_tvalid && s_axis_tready;
    assign w_cfg_take  = i_cfg_valid && o_cfg_ready;
    assign w_mode      = t_mode'(s_axis_tuser);
    assign w_full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_query_go  = (w_mode == MODE_QUERY) && !w_empty && (r_period != '0);
    assign w_last_full = r_count - CNT_W'(1);
    assign w_last      = w_last_full[IDX_W-1:0];

    // fields of the row read last cycle
    assign w_rd_high = r_rdata[PRICE_WIDTH-1:0];
    assign w_rd_low  = r_rdata[2*PRICE_WIDTH-1:PRICE_WIDTH];
    assign w_rd_open = r_rdata[3*PRICE_WIDTH-1:2*PRICE_WIDTH];
    assign w_rd_time = r_rdata[ROW_W-1:3*PRICE_WIDTH];

    // bisection midpoint and loop test
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_bis_mid = w_mid_sum[IDX_W:1];
    assign w_gap     = r_hi - r_lo;
    assign w_more    = (w_gap > IDX_W'(1));

    // number of earlier bars summed, cut at the table start
    assign w_base_big = (CMP_W'(r_base) >= CMP_W'(r_period));
    assign w_terms    = w_base_big ? r_period : PERIOD_W'(r_base);

    // range of one bar, signed
    assign w_diff = $signed(SUM_W'(w_rd_high)) - $signed(SUM_W'(w_rd_low));

    // magnitude of the range sum
    assign w_sum_abs = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_mag     = w_sum_abs[MAG_W-1:0];

    // restoring divider step, one quotient bit a cycle
    assign w_trial     = {r_rem, r_quo[DIV_W-1]};
    assign w_trial_ge  = (w_trial >= {1'b0, r_period});
    assign w_trial_sub = w_trial - {1'b0, r_period};

    // shared level adder: mid plus or minus the full or half range
    assign w_lv_base = LEVEL_W'({r_open, {FRACTION_BITS{1'b0}}});
    assign w_amag    = LEVEL_W'(r_quo);
    assign w_hmag    = LEVEL_W'(r_quo >> 1);
    assign w_lv_b    = ((r_lstep == LS_TOP) || (r_lstep == LS_BOTTOM)) ? w_amag : w_hmag;
    assign w_lv_sub  = r_neg ^ ((r_lstep == LS_LOWER) || (r_lstep == LS_BOTTOM));
    assign w_lv_res  = w_lv_sub ? (r_lv_mid - w_lv_b) : (r_lv_mid + w_lv_b);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_state = w_query_go ? S_FIRST_RD : S_DONE;
                end
            end
            S_FIRST_RD:  n_state = S_FIRST_CHK;
            S_FIRST_CHK: n_state = (r_tgt <= w_rd_time) ? S_SUM_INIT : S_LAST_RD;
            S_LAST_RD:   n_state = S_LAST_CHK;
            S_LAST_CHK:  n_state = (r_tgt >= w_rd_time) ? S_SUM_INIT : S_BIS_SEL;
            S_BIS_SEL:   n_state = w_more ? S_BIS_RD : S_SUM_INIT;
            S_BIS_RD:    n_state = S_BIS_CHK;
            S_BIS_CHK:   n_state = S_BIS_SEL;
            S_SUM_INIT:  n_state = S_OPEN_RD;
            S_OPEN_RD:   n_state = S_OPEN_GET;
            S_OPEN_GET:  n_state = S_SUM_SEL;
            S_SUM_SEL:   n_state = (r_left == '0) ? S_DIV : S_SUM_ACC;
            S_SUM_ACC:   n_state = S_SUM_SEL;
            S_DIV:       n_state = (r_dcnt == DCNT_W'(1)) ? S_ZERO_CHK : S_DIV;
            S_ZERO_CHK:  n_state = (r_quo == '0) ? S_DONE : S_LEVEL;
            S_LEVEL:     n_state = (r_lstep == LS_BOTTOM) ? S_DONE : S_LEVEL;
            S_DONE:      n_state = (!r_out_valid || m_axis_tready) ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        o_cfg_ready   = (r_state == S_IDLE);
        w_out_load    = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
        w_mem_wr      = w_in_take && (w_mode == MODE_APPEND) && !w_full;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_period    <= PERIOD_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_take && (w_mode == MODE_CLEAR)) begin
                r_count <= '0;
            end else if (w_mem_wr) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_cfg_take) begin
                r_period <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // bar table: one write port on append, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_wr) begin
            r_mem[r_count[IDX_W-1:0]] <= s_axis_tdata[ROW_W-1:0];
        end
        r_rdata <= r_mem[r_addr];
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    r_tgt       <= s_axis_tdata[ROW_W-1:3*PRICE_WIDTH];
                    r_addr      <= '0;
                    r_lv_top    <= '0;
                    r_lv_upper  <= '0;
                    r_lv_mid    <= '0;
                    r_lv_lower  <= '0;
                    r_lv_bottom <= '0;
                    case (w_mode)
                        MODE_CLEAR:  r_status <= STS_CLEARED;
                        MODE_APPEND: r_status <= w_full ? STS_FULL : STS_STORED;
                        default:     r_status <= STS_NO_LEVELS;
                    endcase
                end
            end
            S_FIRST_CHK: begin
                r_base <= '0;
                r_addr <= w_last;
            end
            S_LAST_CHK: begin
                r_base <= w_last;
                r_lo   <= '0;
                r_hi   <= w_last;
            end
            S_BIS_SEL: begin
                r_addr <= w_bis_mid;
                r_base <= r_lo;
            end
            S_BIS_CHK: begin
                if (w_rd_time <= r_tgt) begin
                    r_lo <= r_addr;
                end else begin
                    r_hi <= r_addr;
                end
            end
            S_SUM_INIT: begin
                r_addr <= r_base;
                r_left <= w_terms;
                r_sum  <= '0;
            end
            S_OPEN_GET: begin
                r_open <= w_rd_open;
                r_addr <= r_base - IDX_W'(1);
            end
            S_SUM_SEL: begin
                if (r_left == '0) begin
                    r_neg  <= r_sum[SUM_W-1];
                    r_quo  <= {w_mag, {FRACTION_BITS{1'b0}}};
                    r_rem  <= '0;
                    r_dcnt <= DCNT_W'(DIV_W);
                end
            end
            S_SUM_ACC: begin
                r_sum  <= r_sum + w_diff;
                r_left <= r_left - PERIOD_W'(1);
                r_addr <= r_addr - IDX_W'(1);
            end
            S_DIV: begin
                r_rem  <= w_trial_ge ? w_trial_sub[PERIOD_W-1:0] : w_trial[PERIOD_W-1:0];
                r_quo  <= {r_quo[DIV_W-2:0], w_trial_ge};
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end
            S_ZERO_CHK: begin
                if (r_quo != '0) begin
                    r_lv_mid <= w_lv_base;
                    r_lstep  <= LS_TOP;
                    r_status <= STS_LEVELS;
                end
            end
            S_LEVEL: begin
                case (r_lstep)
                    LS_TOP:    r_lv_top    <= w_lv_res;
                    LS_UPPER:  r_lv_upper  <= w_lv_res;
                    LS_LOWER:  r_lv_lower  <= w_lv_res;
                    LS_BOTTOM: r_lv_bottom <= w_lv_res;
                    default:   r_lv_top    <= w_lv_res;
                endcase
                r_lstep <= t_lstep'(r_lstep + 2'd1);
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_levels <= {r_lv_bottom, r_lv_lower, r_lv_mid, r_lv_upper, r_lv_top};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_levels};
    assign m_axis_tuser  = r_out_status;

endmodule

@@ hdl/arbl_checker.sv @@
// port-level checks of the range band levels block, bound to its top level
// depends on arbl_pkg and average_range_band_levels_macros.svh
`include "average_range_band_levels_macros.svh"

module arbl_checker
    import arbl_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OUT_DW-1:0]   m_axis_tdata,
    input logic [STATUS_W-1:0] m_axis_tuser
);

    logic [LEVEL_W-1:0] w_top;
    logic [LEVEL_W-1:0] w_upper;
    logic [LEVEL_W-1:0] w_mid;
    logic [LEVEL_W-1:0] w_lower;
    logic [LEVEL_W-1:0] w_bottom;
    logic [LEVEL_W-1:0] w_outer_sum;
    logic [LEVEL_W-1:0] w_inner_sum;
    logic [LEVEL_W-1:0] w_mid_x2;

    // level fields of the result word
    assign w_top    = m_axis_tdata[LEVEL_W-1:0];
    assign w_upper  = m_axis_tdata[2*LEVEL_W-1:LEVEL_W];
    assign w_mid    = m_axis_tdata[3*LEVEL_W-1:2*LEVEL_W];
    assign w_lower  = m_axis_tdata[4*LEVEL_W-1:3*LEVEL_W];
    assign w_bottom = m_axis_tdata[5*LEVEL_W-1:4*LEVEL_W];

    // band symmetry around the open, modulo the level width
    assign w_outer_sum = w_top + w_bottom;
    assign w_inner_sum = w_upper + w_lower;
    assign w_mid_x2    = {w_mid[LEVEL_W-2:0], 1'b0};

    // a stalled result word holds
    `ARBL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // any word other than valid levels carries all-zero level fields
    `ARBL_ASSERT_IMP(a_zero_levels, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != STS_LEVELS), m_axis_tdata == '0)

    // outer and half levels sit symmetric about the mid level
    `ARBL_ASSERT_IMP(a_band_sym, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == STS_LEVELS), (w_outer_sum == w_mid_x2) && (w_inner_sum == w_mid_x2))

    // the block drops its input ready in the cycle after taking a word
    `ARBL_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind average_range_band_levels arbl_checker u_arbl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ test/tb_average_range_band_levels.sv @@
// self-checking testbench for average_range_band_levels: directed and random words,
// an own bar table predicting every result word; depends on arbl_pkg and the top level
module tb_average_range_band_levels;
    import arbl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_DW        = ((3 * PRICE_WIDTH_DEF + STAMP_W + 7) / 8) * 8;
    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_WORDS = 220;
    localparam int LONG_BARS    = 280;
    localparam int STALL_PCT    = 21;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // one pending input word or one period write
    typedef struct {
        bit                         is_cfg;
        logic [PERIOD_W-1:0]        period;
        logic [MODE_W-1:0]          mode;
        logic [PRICE_WIDTH_DEF-1:0] bar_high;
        logic [PRICE_WIDTH_DEF-1:0] bar_low;
        logic [PRICE_WIDTH_DEF-1:0] bar_open;
        logic [STAMP_W-1:0]         stamp;
    } bar_word_t;

    // one predicted result word, levels from top (index 0) to bottom
    typedef struct packed {
        logic [STATUS_W-1:0]                status;
        logic [NUM_LEVELS-1:0][LEVEL_W-1:0] lvl;
    } band_result_t;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // bar_high, bar_low, bar_open, stamp
    logic [IN_DW-1:0]      s_axis_tdata  = '0;
    // mode
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // level_top, level_upper_half, level_mid, level_lower_half, level_bottom, zero pad
    logic [OUT_DW-1:0]     m_axis_tdata;
    // status
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [PERIOD_W-1:0]   i_cfg_data    = '0;

    // stimulus and expectation stores
    bar_word_t    pending_q [$];
    band_result_t band_q [$];

    // predictor copy of the bar table and the period register
    logic [PRICE_WIDTH_DEF-1:0] high_tab [TABLE_DEPTH_DEF];
    logic [PRICE_WIDTH_DEF-1:0] low_tab  [TABLE_DEPTH_DEF];
    logic [PRICE_WIDTH_DEF-1:0] open_tab [TABLE_DEPTH_DEF];
    logic [STAMP_W-1:0]         time_tab [TABLE_DEPTH_DEF];
    int unsigned                bars_held  = 0;
    logic [PERIOD_W-1:0]        period_reg = PERIOD_RST;

    bar_word_t           in_flight;
    logic [PERIOD_W-1:0] cfg_flight;

    int   mismatch_count = 0;
    int   words_sent     = 0;
    int   queries_sent   = 0;
    int   results_seen   = 0;
    int   levels_seen    = 0;
    int   periods_set    = 0;
    int   counted_words  = 0;
    int   quiet_cycles   = 0;
    int   cycle_no       = 0;
    logic calm           = 1'b0;

    string level_name [NUM_LEVELS] = '{"top", "upper_half", "mid", "lower_half", "bottom"};

    average_range_band_levels dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // last stored bar at or below the target, bisection clamped to both ends
    function automatic int unsigned locate_bar(logic [STAMP_W-1:0] target);
        int unsigned last_idx;
        int unsigned lo_idx;
        int unsigned hi_idx;
        int unsigned probe;
        last_idx = bars_held - 1;
        lo_idx   = 0;
        hi_idx   = last_idx;
        if (target <= time_tab[0]) return 0;
        if (target >= time_tab[last_idx]) return last_idx;
        while (hi_idx - lo_idx > 1) begin
            probe = (lo_idx + hi_idx) / 2;
            if (time_tab[probe] <= target) lo_idx = probe;
            else hi_idx = probe;
        end
        return lo_idx;
    endfunction

    // updates the table copy and forms the result word of one input word
    function automatic band_result_t predict_band(bar_word_t w);
        band_result_t      r;
        int unsigned       anchor;
        int unsigned       k;
        longint            span_sum;
        longint unsigned   mag;
        longint unsigned   per;
        longint unsigned   avg;
        longint unsigned   adr;
        longint unsigned   half;
        longint unsigned   mid_v;
        r.status = STS_NO_LEVELS;
        r.lvl    = '0;
        case (w.mode)
            MODE_CLEAR: begin
                bars_held = 0;
                r.status  = STS_CLEARED;
            end
            MODE_APPEND: begin
                if (bars_held < TABLE_DEPTH_DEF) begin
                    high_tab[bars_held] = w.bar_high;
                    low_tab[bars_held]  = w.bar_low;
                    open_tab[bars_held] = w.bar_open;
                    time_tab[bars_held] = w.stamp;
                    bars_held++;
                    r.status = STS_STORED;
                end else begin
                    r.status = STS_FULL;
                end
            end
            MODE_QUERY: begin
                if (bars_held != 0 && period_reg != 0) begin
                    anchor   = locate_bar(w.stamp);
                    span_sum = 0;
                    for (k = 1; k <= period_reg && k <= anchor; k++) begin
                        span_sum += $signed({32'd0, high_tab[anchor-k]})
                                  - $signed({32'd0, low_tab[anchor-k]});
                    end
                    mag = (span_sum < 0) ? -span_sum : span_sum;
                    per = period_reg;
                    avg = ((mag / per) << FRACTION_BITS_DEF)
                        + (((mag % per) << FRACTION_BITS_DEF) / per);
                    if (avg != 0) begin
                        // signed range and half range, truncated toward zero
                        half  = avg >> 1;
                        adr   = (span_sum < 0) ? -avg : avg;
                        half  = (span_sum < 0) ? -half : half;
                        mid_v = longint'({24'd0, open_tab[anchor]}) << FRACTION_BITS_DEF;
                        r.status = STS_LEVELS;
                        r.lvl[0] = LEVEL_W'(mid_v + adr);
                        r.lvl[1] = LEVEL_W'(mid_v + half);
                        r.lvl[2] = LEVEL_W'(mid_v);
                        r.lvl[3] = LEVEL_W'(mid_v - half);
                        r.lvl[4] = LEVEL_W'(mid_v - adr);
                    end
                end
            end
            default: r.status = STS_NO_LEVELS;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch on result word %0d: %s", results_seen, msg);
    endtask

    function automatic logic [STAMP_W-1:0] rand_stamp();
        return {8'($urandom_range(0, 255)), 32'($urandom)};
    endfunction

    function automatic void queue_word(logic [MODE_W-1:0] m, logic [31:0] h, logic [31:0] l,
                                       logic [31:0] o, logic [STAMP_W-1:0] st);
        bar_word_t w;
        w.is_cfg   = 1'b0;
        w.period   = '0;
        w.mode     = m;
        w.bar_high = h;
        w.bar_low  = l;
        w.bar_open = o;
        w.stamp    = st;
        pending_q.push_back(w);
        if (m != MODE_UNUSED) counted_words++;
    endfunction

    function automatic void queue_period(logic [PERIOD_W-1:0] p);
        bar_word_t w;
        w        = '{default: '0};
        w.is_cfg = 1'b1;
        w.period = p;
        pending_q.push_back(w);
    endfunction

    // clear, a run of bars with random content, then queries around their stamps
    task automatic queue_session(int n_bars, bit ordered);
        logic [STAMP_W-1:0] stamps [$];
        logic [STAMP_W-1:0] st;
        logic [31:0]        base;
        logic [31:0]        h;
        logic [31:0]        l;
        logic [31:0]        o;
        int                 pick;
        queue_word(MODE_CLEAR, $urandom, $urandom, $urandom, rand_stamp());
        if ($urandom_range(0, 7) == 0)
            queue_word(MODE_QUERY, $urandom, $urandom, $urandom, rand_stamp());
        base = $urandom;
        st   = {8'($urandom_range(0, 254)), 32'($urandom)};
        for (int i = 0; i < n_bars; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                h = $urandom;
                l = $urandom;
                o = $urandom;
            end else begin
                l = base + $urandom_range(0, 4000);
                h = l + $urandom_range(0, 3000);
                o = l + $urandom_range(0, 3000);
            end
            if (ordered) st = st + $urandom_range(1, 65536);
            else st = rand_stamp();
            stamps.push_back(st);
            queue_word(MODE_APPEND, h, l, o, st);
            if ($urandom_range(0, 15) == 0)
                queue_word(MODE_UNUSED, $urandom, $urandom, $urandom, rand_stamp());
        end
        for (int q = $urandom_range(2, 6); q > 0; q--) begin
            pick = $urandom_range(0, 19);
            if (pick < 10) st = stamps[$urandom_range(0, stamps.size() - 1)];
            else if (pick < 15)
                st = stamps[$urandom_range(0, stamps.size() - 1)] + $urandom_range(0, 200) - 100;
            else if (pick < 17) st = '0;
            else if (pick < 18) st = '1;
            else st = rand_stamp();
            queue_word(MODE_QUERY, $urandom, $urandom, $urandom, st);
        end
    endtask

    // stimulus, reset and end of run
    initial begin
        int          start_words;
        logic [39:0] st;
        // directed: empty table, extreme prices, negative and zero sums, clamping
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd0);
        queue_word(MODE_APPEND, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 40'd10);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd10);
        queue_word(MODE_APPEND, 32'd0, 32'hFFFF_FFFF, 32'd0, 40'd20);
        queue_word(MODE_APPEND, 32'd5, 32'hFFFF_0000, 32'h1234_5678, 40'd30);
        queue_word(MODE_APPEND, 32'd2000, 32'd1990, 32'd1995, 40'd40);
        queue_word(MODE_APPEND, 32'd5000, 32'd4000, 32'd0, 40'hFF_FFFF_FFFF);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd0);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd20);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd25);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd30);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd35);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd40);
        queue_word(MODE_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        queue_word(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd45);
        queue_word(MODE_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd20);
        // shortest period on two new bars
        queue_period(8'd1);
        queue_word(MODE_APPEND, 32'd100, 32'd300, 32'd50, 40'd1);
        queue_word(MODE_APPEND, 32'd700, 32'd200, 32'd0, 40'd2);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd2);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd1);
        // zero period answers no levels
        queue_period(8'd0);
        queue_word(MODE_QUERY,  32'd0, 32'd0, 32'd0, 40'd2);
        // longest period over a run of bars longer than the period
        queue_period(8'd255);
        queue_word(MODE_CLEAR, $urandom, $urandom, $urandom, rand_stamp());
        st = 40'd1000;
        for (int i = 0; i < LONG_BARS; i++) begin
            st = st + $urandom_range(1, 1000);
            queue_word(MODE_APPEND, 32'd60000 + $urandom_range(0, 9000),
                       32'd50000 + $urandom_range(0, 9000), $urandom, st);
        end
        queue_word(MODE_QUERY, $urandom, $urandom, $urandom, '1);
        queue_word(MODE_QUERY, $urandom, $urandom, $urandom, '0);
        for (int i = 0; i < 8; i++)
            queue_word(MODE_QUERY, $urandom, $urandom, $urandom,
                       40'd1000 + $urandom_range(0, LONG_BARS * 500));
        // random phases, each under its own period
        start_words = counted_words;
        while (counted_words - start_words < RANDOM_WORDS) begin
            case ($urandom_range(0, 5))
                0: queue_period(8'd1);
                1: queue_period(8'd255);
                2: queue_period(8'($urandom_range(2, 8)));
                3: queue_period(8'($urandom_range(9, 40)));
                4: queue_period(PERIOD_RST);
                default: queue_period(8'($urandom_range(1, 255)));
            endcase
            for (int s = $urandom_range(2, 4); s > 0; s--)
                queue_session($urandom_range(0, 3) == 0 ? $urandom_range(1, 4)
                                                        : $urandom_range(5, 40),
                              $urandom_range(0, 4) != 0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_axis_tvalid || i_cfg_valid || band_q.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("covered %0d input words, %0d of them queries, and %0d period writes",
                 words_sent, queries_sent, periods_set);
        $display("checked %0d result words, %0d carrying levels", results_seen, levels_seen);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // quiet cycle count and calm window
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        calm     <= (cycle_no >= 3000 && cycle_no < 9000);
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                     || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("no word moved for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // driver: input words and period writes from the pending queue
    always @(posedge i_clk) begin
        bar_word_t nxt;
        bit        s_busy;
        bit        c_busy;
        bit        drive_s;
        bit        drive_c;
        bit        start_s;
        bit        start_c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
        end else begin
            s_busy  = s_axis_tvalid && !s_axis_tready;
            c_busy  = i_cfg_valid && !o_cfg_ready;
            drive_s = s_busy;
            drive_c = c_busy;
            start_s = 1'b0;
            start_c = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                band_q.push_back(predict_band(in_flight));
                words_sent++;
                if (in_flight.mode == MODE_QUERY) queries_sent++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                period_reg = cfg_flight;
                periods_set++;
            end
            if (!s_busy && !c_busy && pending_q.size() != 0) begin
                if (pending_q[0].is_cfg) begin
                    // period changes only once every result is back
                    if (band_q.size() == 0) begin
                        nxt        = pending_q.pop_front();
                        cfg_flight = nxt.period;
                        drive_c    = 1'b1;
                        start_c    = 1'b1;
                    end
                end else if (calm || $urandom_range(0, 99) >= STALL_PCT) begin
                    in_flight = pending_q.pop_front();
                    drive_s   = 1'b1;
                    start_s   = 1'b1;
                end
            end
            s_axis_tvalid <= drive_s;
            i_cfg_valid   <= drive_c;
            if (start_s) begin
                s_axis_tdata <= IN_DW'({in_flight.stamp, in_flight.bar_open,
                                        in_flight.bar_low, in_flight.bar_high});
                s_axis_tuser <= in_flight.mode;
            end
            if (start_c) i_cfg_data <= cfg_flight;
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        band_result_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (band_q.size() == 0) begin
                    report_mismatch("result word with no prediction waiting");
                end else begin
                    want = band_q.pop_front();
                    if (want.status == STS_LEVELS) levels_seen++;
                    if (m_axis_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  m_axis_tuser, want.status));
                    for (int i = 0; i < NUM_LEVELS; i++) begin
                        if (m_axis_tdata[i*LEVEL_W +: LEVEL_W] !== want.lvl[i])
                            report_mismatch($sformatf("level_%s %h, predicted %h",
                                level_name[i], m_axis_tdata[i*LEVEL_W +: LEVEL_W],
                                want.lvl[i]));
                    end
                end
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
        end
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/arbl_pkg.sv
hdl/average_range_band_levels.sv
hdl/arbl_checker.sv
test/tb_average_range_band_levels.sv
